@@ hw/rtl/utgl_pkg.sv @@
// Shared types and constants for the UTF-8 text glyph layout block.
// Used by every module under hw/rtl; depends on nothing else.
package utgl_pkg;

    localparam int GLYPH_WIDTH_DEF  = 8;
    localparam int GLYPH_HEIGHT_DEF = 16;
    localparam int GLYPH_COUNT_DEF  = 108;

    localparam int CP_W    = 21;
    localparam int IDX_W   = 7;
    localparam int POS_W   = 16;
    localparam int SCALE_W = 8;

    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    localparam logic [1:0] REG_ORIGIN_X    = 2'd0;
    localparam logic [1:0] REG_ORIGIN_Y    = 2'd1;
    localparam logic [1:0] REG_GLYPH_SCALE = 2'd2;

    localparam logic [CP_W-1:0]  ASCII_LO   = 21'd32;
    localparam logic [CP_W-1:0]  ASCII_HI   = 21'd127;
    localparam logic [CP_W-1:0]  CP_NEWLINE = 21'd10;
    localparam logic [IDX_W-1:0] EXTRA_BASE = 7'd96;
    localparam int               EXTRA_N    = 12;

    localparam logic [CP_W-1:0] EXTRA_CODES [EXTRA_N] = '{
        21'd161, 21'd191, 21'd209, 21'd225, 21'd233, 21'd237,
        21'd241, 21'd243, 21'd250, 21'd252, 21'd26376, 21'd20320
    };

    typedef struct packed {
        logic signed [POS_W-1:0] origin_x;
        logic signed [POS_W-1:0] origin_y;
        logic [SCALE_W-1:0]      glyph_scale;
    } cfg_t;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             valid;
    } glyph_t;

    typedef struct packed {
        logic                    emit;
        logic [IDX_W-1:0]        glyph_index;
        logic                    glyph_valid;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic                    end_of_text;
    } result_t;

endpackage

@@ hw/rtl/utgl_cfg.sv @@
// APB-style register file holding origin_x, origin_y and glyph_scale.
// Depends on utgl_pkg.
module utgl_cfg (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [utgl_pkg::APB_AW-1:0]  paddr,
    input  logic [utgl_pkg::APB_DW-1:0]  pwdata,
    output logic [utgl_pkg::APB_DW-1:0]  prdata,
    output logic                         pready,
    output utgl_pkg::cfg_t               cfg
);
    import utgl_pkg::*;

    logic signed [POS_W-1:0] origin_x_reg;
    logic signed [POS_W-1:0] origin_y_reg;
    logic [SCALE_W-1:0]      glyph_scale_reg;
    logic                    wr_en;
    logic [1:0]              reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_sel = paddr[3:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_x_reg    <= '0;
            origin_y_reg    <= '0;
            glyph_scale_reg <= SCALE_W'(1);
        end else if (wr_en) begin
            case (reg_sel)
                REG_ORIGIN_X:    origin_x_reg    <= pwdata[POS_W-1:0];
                REG_ORIGIN_Y:    origin_y_reg    <= pwdata[POS_W-1:0];
                REG_GLYPH_SCALE: glyph_scale_reg <= pwdata[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_ORIGIN_X:    prdata = APB_DW'(unsigned'(origin_x_reg));
            REG_ORIGIN_Y:    prdata = APB_DW'(unsigned'(origin_y_reg));
            REG_GLYPH_SCALE: prdata = APB_DW'(glyph_scale_reg);
            default:         prdata = '0;
        endcase
    end

    assign cfg.origin_x    = origin_x_reg;
    assign cfg.origin_y    = origin_y_reg;
    assign cfg.glyph_scale = glyph_scale_reg;

endmodule

@@ hw/rtl/utgl_lookup.sv @@
// Character table lookup: maps a codepoint to its glyph index and draw flag.
// Depends on utgl_pkg for the table of extra codepoints.
module utgl_lookup #(
    parameter int GLYPH_COUNT = utgl_pkg::GLYPH_COUNT_DEF
) (
    input  logic [utgl_pkg::CP_W-1:0] cp,
    output utgl_pkg::glyph_t          glyph
);
    import utgl_pkg::*;

    logic             hit;
    logic [IDX_W-1:0] idx;

    always_comb begin
        hit = 1'b0;
        idx = '0;
        if (cp >= ASCII_LO && cp <= ASCII_HI) begin
            hit = 1'b1;
            idx = IDX_W'(cp - ASCII_LO);
        end else begin
            for (int i = 0; i < EXTRA_N; i++) begin
                if (cp == EXTRA_CODES[i]) begin
                    hit = 1'b1;
                    idx = EXTRA_BASE + IDX_W'(i);
                end
            end
        end
    end

    assign glyph.idx   = idx;
    assign glyph.valid = hit && (32'(idx) < GLYPH_COUNT);

endmodule

@@ hw/rtl/utgl_core.sv @@
// UTF-8 decoder state, cursor tracking and result formation for one byte.
// Depends on utgl_pkg and utgl_lookup.
module utgl_core #(
    parameter int GLYPH_WIDTH  = utgl_pkg::GLYPH_WIDTH_DEF,
    parameter int GLYPH_HEIGHT = utgl_pkg::GLYPH_HEIGHT_DEF,
    parameter int GLYPH_COUNT  = utgl_pkg::GLYPH_COUNT_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              fire,
    input  logic [7:0]        text_byte,
    input  logic              string_start,
    input  utgl_pkg::cfg_t    cfg,
    output utgl_pkg::result_t res
);
    import utgl_pkg::*;

    localparam int XADV_MAX = GLYPH_WIDTH * 255;
    localparam int YADV_MAX = (GLYPH_HEIGHT + 2) * 255;
    localparam int ADV_MAX  = (XADV_MAX > YADV_MAX) ? XADV_MAX : YADV_MAX;
    localparam int ADV_W    = $clog2(ADV_MAX + 1);
    localparam int SUM_W    = ((ADV_W + 1 > POS_W) ? ADV_W + 1 : POS_W) + 1;
    localparam logic signed [SUM_W-1:0] POS_MAX = SUM_W'(32767);
    localparam logic signed [SUM_W-1:0] POS_MIN = SUM_W'(-32768);

    function automatic logic signed [POS_W-1:0] sat16(input logic signed [SUM_W-1:0] v);
        logic signed [POS_W-1:0] r;
        if (v > POS_MAX) begin
            r = POS_MAX[POS_W-1:0];
        end else if (v < POS_MIN) begin
            r = POS_MIN[POS_W-1:0];
        end else begin
            r = v[POS_W-1:0];
        end
        return r;
    endfunction

    logic [1:0]              pend_reg, pend_next;
    logic [CP_W-1:0]         part_reg, part_next;
    logic signed [POS_W-1:0] cx_reg, cx_next;
    logic signed [POS_W-1:0] cy_reg, cy_next;
    logic                    stop_reg, stop_next;

    logic [1:0]              pend_eff, pend_dec;
    logic [CP_W-1:0]         part_eff, part_dec, cp_shift;
    logic signed [POS_W-1:0] cx_eff, cy_eff;
    logic                    stop_eff;
    logic                    dec_finish, code_go;
    logic [CP_W-1:0]         code_cp;
    glyph_t                  glyph;
    logic [ADV_W-1:0]        xadv, yadv;
    logic signed [SUM_W-1:0] x_sum, y_sum;
    logic                    finish;

    assign cx_eff   = string_start ? cfg.origin_x : cx_reg;
    assign cy_eff   = string_start ? cfg.origin_y : cy_reg;
    assign pend_eff = string_start ? 2'd0 : pend_reg;
    assign part_eff = string_start ? '0 : part_reg;
    assign stop_eff = string_start ? 1'b0 : stop_reg;
    assign cp_shift = {part_eff[CP_W-7:0], text_byte[5:0]};

    always_comb begin
        dec_finish = 1'b0;
        code_go    = 1'b0;
        code_cp    = cp_shift;
        pend_dec   = pend_eff;
        part_dec   = part_eff;
        if (!stop_eff) begin
            if (text_byte == 8'd0) begin
                dec_finish = 1'b1;
            end else if (pend_eff != 2'd0) begin
                part_dec = cp_shift;
                pend_dec = pend_eff - 2'd1;
                code_go  = (pend_eff == 2'd1);
            end else if (!text_byte[7]) begin
                code_go = 1'b1;
                code_cp = CP_W'(text_byte);
            end else if (text_byte[7:5] == 3'b110) begin
                part_dec = CP_W'(text_byte[4:0]);
                pend_dec = 2'd1;
            end else if (text_byte[7:4] == 4'b1110) begin
                part_dec = CP_W'(text_byte[3:0]);
                pend_dec = 2'd2;
            end else if (text_byte[7:3] == 5'b11110) begin
                part_dec = CP_W'(text_byte[2:0]);
                pend_dec = 2'd3;
            end else begin
                dec_finish = 1'b1;
            end
        end
    end

    utgl_lookup #(
        .GLYPH_COUNT(GLYPH_COUNT)
    ) u_lookup (
        .cp   (code_cp),
        .glyph(glyph)
    );

    assign xadv  = ADV_W'(cfg.glyph_scale) * ADV_W'(GLYPH_WIDTH);
    assign yadv  = ADV_W'(cfg.glyph_scale) * ADV_W'(GLYPH_HEIGHT + 2);
    assign x_sum = SUM_W'(cx_eff) + $signed(SUM_W'(xadv));
    assign y_sum = SUM_W'(cy_eff) + $signed(SUM_W'(yadv));

    always_comb begin
        finish          = dec_finish;
        res.emit        = 1'b0;
        res.glyph_index = glyph.idx;
        res.glyph_valid = glyph.valid;
        res.pos_x       = cx_eff;
        res.pos_y       = cy_eff;
        res.end_of_text = 1'b0;
        cx_next         = cx_eff;
        cy_next         = cy_eff;
        pend_next       = pend_dec;
        part_next       = part_dec;
        stop_next       = stop_eff;
        if (code_go) begin
            if (code_cp == '0) begin
                finish = 1'b1;
            end else if (code_cp == CP_NEWLINE) begin
                cx_next = cfg.origin_x;
                cy_next = sat16(y_sum);
            end else begin
                res.emit = 1'b1;
                cx_next  = sat16(x_sum);
            end
        end
        if (finish) begin
            res.emit        = 1'b1;
            res.end_of_text = 1'b1;
            res.glyph_index = '0;
            res.glyph_valid = 1'b0;
            stop_next       = 1'b1;
            pend_next       = 2'd0;
            part_next       = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= 2'd0;
            part_reg <= '0;
            cx_reg   <= '0;
            cy_reg   <= '0;
            stop_reg <= 1'b1;
        end else if (fire) begin
            pend_reg <= pend_next;
            part_reg <= part_next;
            cx_reg   <= cx_next;
            cy_reg   <= cy_next;
            stop_reg <= stop_next;
        end
    end

endmodule

@@ hw/rtl/utf8_text_glyph_layout.sv @@
// Top level of the UTF-8 text glyph layout block: stream ports, input and
// result registers. Depends on utgl_pkg, utgl_cfg and utgl_core.
//
// The block takes one text byte per clock cycle while the result side does
// not stall, and places one glyph per decoded codepoint but newlines.
// A byte is captured in an input register, then decoded, looked up in the
// character table and applied to the cursor as it leaves that register, and
// the result is held in an output register, from which it is offered. Bytes
// that start or continue a UTF-8 sequence without completing it, newlines
// and bytes seen after the end of a text give no transaction on the result
// side. The sustained rate, set by the single decode and cursor update
// step, is one byte per cycle while the result side does not stall. While
// a result waits on the output register, the next byte waits in the input
// register and the input stalls once that is full.
module utf8_text_glyph_layout #(
    parameter int GLYPH_WIDTH  = utgl_pkg::GLYPH_WIDTH_DEF,
    parameter int GLYPH_HEIGHT = utgl_pkg::GLYPH_HEIGHT_DEF,
    parameter int GLYPH_COUNT  = utgl_pkg::GLYPH_COUNT_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // tdata[7:0] text_byte
    input  logic [7:0]                   s_axis_tdata,
    // tuser[0] string_start
    input  logic [0:0]                   s_axis_tuser,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // tdata[6:0] glyph_index, [22:7] pos_x, [38:23] pos_y, [39] zero
    output logic [39:0]                  m_axis_tdata,
    // tuser[0] glyph_valid
    output logic [0:0]                   m_axis_tuser,
    output logic                         m_axis_tlast,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [utgl_pkg::APB_AW-1:0]  paddr,
    input  logic [utgl_pkg::APB_DW-1:0]  pwdata,
    output logic [utgl_pkg::APB_DW-1:0]  prdata,
    output logic                         pready
);
    import utgl_pkg::*;

    cfg_t       cfg;
    result_t    res;
    logic       in_v_reg;
    logic [7:0] byte_reg;
    logic       start_reg;
    logic       advance;
    logic       out_v_reg;
    result_t    out_reg;

    utgl_cfg u_cfg (
        .aclk   (aclk),
        .aresetn(aresetn),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready),
        .cfg    (cfg)
    );

    assign advance       = in_v_reg && (!out_v_reg || m_axis_tready);
    assign s_axis_tready = !in_v_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_v_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_v_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            byte_reg  <= s_axis_tdata;
            start_reg <= s_axis_tuser[0];
        end
    end

    utgl_core #(
        .GLYPH_WIDTH (GLYPH_WIDTH),
        .GLYPH_HEIGHT(GLYPH_HEIGHT),
        .GLYPH_COUNT (GLYPH_COUNT)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .fire        (advance),
        .text_byte   (byte_reg),
        .string_start(start_reg),
        .cfg         (cfg),
        .res         (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
        end else if (advance && res.emit) begin
            out_v_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res.emit) begin
            out_reg <= res;
        end
    end

    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = {1'b0, out_reg.pos_y, out_reg.pos_x, out_reg.glyph_index};
    assign m_axis_tuser  = out_reg.glyph_valid;
    assign m_axis_tlast  = out_reg.end_of_text;

endmodule
